[rtl/oneshot_esc_pulse_generator_defines.svh]
// Assertion macros shared by the pulse generator checkers.
`ifndef ONESHOT_ESC_PULSE_GENERATOR_DEFINES_SVH
`define ONESHOT_ESC_PULSE_GENERATOR_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define OESC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pulse generator check failed");

// Check that one condition is followed by another on the next edge.
`define OESC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pulse generator sequence check failed");

`endif

[rtl/oesc_pkg.sv]
// Types, constants and helper functions of the pulse generator.
package oesc_pkg;

  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned TPU_W    = 10;
  localparam int unsigned ACT_W    = 4;
  localparam int unsigned TICK_W   = 18;
  localparam int unsigned PROD_W   = WIDTH_W + TPU_W;
  localparam int unsigned PERIOD_W = 10;
  localparam int unsigned ELAPSE_W = 24;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned NUM_LANES = 8;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_CALIB = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_CHANNELS = 4'd1;

  localparam logic [TPU_W-1:0] TPU_RESET = 10'd100;
  localparam logic [ACT_W-1:0] ACT_RESET = 4'd4;

  localparam logic [PERIOD_W-1:0] PERIOD_US = 10'd1000;
  localparam logic [PERIOD_W-1:0] LOW_US    = 10'd125;
  localparam logic [PERIOD_W-1:0] HIGH_US   = 10'd250;
  localparam logic [ELAPSE_W-1:0] WAIT_US        = 24'd5000000;
  localparam logic [ELAPSE_W-1:0] SHORT_PHASE_US = 24'd1000000;
  localparam logic [ELAPSE_W-1:0] LONG_PHASE_US  = 24'd10000000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_WAIT  = 3'd1,
    PH_SHORT = 3'd2,
    PH_HIGH  = 3'd3,
    PH_LONG  = 3'd4
  } phase_e;

  typedef struct packed {
    phase_e phase_q;
    phase_e phase_d;
    logic   pulse_high;
  } calib_status_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] pin_levels;
    logic                 busy_res;
    logic [2:0]           calib_phase;
    logic                 rejected;
  } result_t;

  function automatic logic [ELAPSE_W-1:0] phase_length(input phase_e ph);
    logic [ELAPSE_W-1:0] len;
    unique case (ph)
      PH_WAIT:  len = WAIT_US;
      PH_SHORT: len = SHORT_PHASE_US;
      default:  len = LONG_PHASE_US;
    endcase
    return len;
  endfunction

endpackage

[rtl/oesc_if.sv]
// Request, result and configuration channel interfaces.
interface oesc_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    mode;
  logic [oesc_pkg::WIDTH_W-1:0]  width_0;
  logic [oesc_pkg::WIDTH_W-1:0]  width_1;
  logic [oesc_pkg::WIDTH_W-1:0]  width_2;
  logic [oesc_pkg::WIDTH_W-1:0]  width_3;
  logic [oesc_pkg::WIDTH_W-1:0]  width_4;
  logic [oesc_pkg::WIDTH_W-1:0]  width_5;
  logic [oesc_pkg::WIDTH_W-1:0]  width_6;
  logic [oesc_pkg::WIDTH_W-1:0]  width_7;
  modport source (output valid, mode, width_0, width_1, width_2, width_3,
                  width_4, width_5, width_6, width_7, input ready);
  modport sink   (input valid, mode, width_0, width_1, width_2, width_3,
                  width_4, width_5, width_6, width_7, output ready);
endinterface

interface oesc_res_if;
  logic                           valid;
  logic                           ready;
  logic [oesc_pkg::NUM_LANES-1:0] pin_levels;
  logic                           busy_res;
  logic [2:0]                     calib_phase;
  logic                           rejected;
  modport source (output valid, pin_levels, busy_res, calib_phase, rejected,
                  input ready);
  modport sink   (input valid, pin_levels, busy_res, calib_phase, rejected,
                  output ready);
endinterface

interface oesc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [oesc_pkg::CFG_IDX_W-1:0]  idx;
  logic [oesc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

[rtl/oneshot_esc_pulse_generator.sv]
// Top level of the multi-channel pulse generator: lanes, merge, calibration, output queue.
// Each result enters the result queue and is shown once earlier results are taken.
// Throughput: one request per cycle while the result queue has room; lane multiplies, end
// compares and calibration timers all update in the cycle of acceptance, and a two-entry
// result queue holds results. Reset: output levels low, result queue empty, idle,
// ticks_per_us 100, active_channels 4; channel targets are loaded by each frame start.
module oneshot_esc_pulse_generator #(
  parameter int unsigned MAX_CHANNELS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  oesc_req_if.sink   req_i,
  oesc_cfg_if.sink   cfg_i,
  oesc_res_if.source res_o
);

  logic [oesc_pkg::TPU_W-1:0]     tpu_q;
  logic [oesc_pkg::ACT_W-1:0]     act_q;
  logic [oesc_pkg::TICK_W-1:0]    ticks_q, ticks_d, ticks_inc;
  logic [oesc_pkg::NUM_LANES-1:0] level_q, level_d;
  logic                           active_q, active_d;
  logic [oesc_pkg::NUM_LANES-1:0] fall;
  logic [oesc_pkg::NUM_LANES-1:0] used_mask;
  logic [oesc_pkg::ACT_W-1:0]     used_n;
  logic [oesc_pkg::WIDTH_W-1:0]   widths [oesc_pkg::NUM_LANES];
  oesc_pkg::calib_status_t        cal;
  oesc_pkg::result_t              res_d, head_q, head_d, tail_q, tail_d;
  logic [1:0]                     cnt_q, cnt_d;
  logic accept, pop, busy, is_start, reject;
  logic start_frame, start_cal, tick, frame_tick, cal_tick;

  assign widths[0] = req_i.width_0;
  assign widths[1] = req_i.width_1;
  assign widths[2] = req_i.width_2;
  assign widths[3] = req_i.width_3;
  assign widths[4] = req_i.width_4;
  assign widths[5] = req_i.width_5;
  assign widths[6] = req_i.width_6;
  assign widths[7] = req_i.width_7;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= oesc_pkg::TPU_RESET;
      act_q <= oesc_pkg::ACT_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.idx)
        oesc_pkg::CFG_TICKS_PER_US:    tpu_q <= cfg_i.data;
        oesc_pkg::CFG_ACTIVE_CHANNELS: act_q <= cfg_i.data[oesc_pkg::ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode
  assign accept      = req_i.valid && req_i.ready;
  assign busy        = active_q || (cal.phase_q != oesc_pkg::PH_IDLE);
  assign is_start    = (req_i.mode == oesc_pkg::MODE_FRAME) ||
                       (req_i.mode == oesc_pkg::MODE_CALIB);
  assign reject      = is_start && busy;
  assign start_frame = accept && !busy && (req_i.mode == oesc_pkg::MODE_FRAME);
  assign start_cal   = accept && !busy && (req_i.mode == oesc_pkg::MODE_CALIB);
  assign tick        = accept && !start_frame && !start_cal;
  assign frame_tick  = tick && active_q;
  assign cal_tick    = tick && !active_q;

  assign used_n = (act_q > oesc_pkg::ACT_W'(MAX_CHANNELS)) ? oesc_pkg::ACT_W'(MAX_CHANNELS)
                                                             : act_q;
  always_comb begin
    for (int i = 0; i < oesc_pkg::NUM_LANES; i++) begin
      used_mask[i] = (oesc_pkg::ACT_W'(i) < used_n);
    end
  end

  assign ticks_inc = (ticks_q == oesc_pkg::TICK_MAX) ? ticks_q
                                                      : ticks_q + oesc_pkg::TICK_W'(1);

  // channel lanes
  for (genvar g = 0; g < oesc_pkg::NUM_LANES; g++) begin : g_lane
    if (g < MAX_CHANNELS) begin : g_used
      oesc_lane u_lane (
        .clk_i   (clk_i),
        .load_i  (start_frame),
        .width_i (widths[g]),
        .tpu_i   (tpu_q),
        .ticks_i (ticks_inc),
        .fall_o  (fall[g])
      );
    end else begin : g_unused
      assign fall[g] = 1'b1;
    end
  end

  oesc_calib u_calib (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_cal),
    .tick_i   (cal_tick),
    .tpu_i    (tpu_q),
    .status_o (cal)
  );

  // merge lane results and calibration pulses into the output levels
  always_comb begin
    ticks_d  = ticks_q;
    level_d  = level_q;
    active_d = active_q;
    priority if (start_frame) begin
      ticks_d  = '0;
      level_d  = used_mask;
      active_d = 1'b1;
    end else if (start_cal) begin
      level_d = '0;
    end else if (frame_tick) begin
      ticks_d  = ticks_inc;
      level_d  = level_q & ~fall;
      active_d = (level_d != '0);
    end else if (cal_tick && cal.phase_q != oesc_pkg::PH_IDLE) begin
      level_d = cal.pulse_high ? used_mask : '0;
    end else begin
      level_d = level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q  <= '0;
      level_q  <= '0;
      active_q <= 1'b0;
    end else begin
      ticks_q  <= ticks_d;
      level_q  <= level_d;
      active_q <= active_d;
    end
  end

  assign res_d.pin_levels  = level_d;
  assign res_d.busy_res    = active_d || (cal.phase_d != oesc_pkg::PH_IDLE);
  assign res_d.calib_phase = cal.phase_d;
  assign res_d.rejected    = reject;

  // two-entry result queue
  assign req_i.ready = (cnt_q != 2'd2);
  assign pop         = res_o.valid && res_o.ready;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    unique case ({accept, pop})
      2'b10: begin
        if (cnt_q == 2'd0) head_d = res_d;
        else tail_d = res_d;
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        head_d = tail_q;
        cnt_d  = cnt_q - 2'd1;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          head_d = res_d;
        end else begin
          head_d = tail_q;
          tail_d = res_d;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign res_o.valid       = (cnt_q != 2'd0);
  assign res_o.pin_levels  = head_q.pin_levels;
  assign res_o.busy_res    = head_q.busy_res;
  assign res_o.calib_phase = head_q.calib_phase;
  assign res_o.rejected    = head_q.rejected;

endmodule

[rtl/oesc_lane.sv]
// One channel lane: width to tick conversion and pulse end compare.
module oesc_lane (
  input  logic                          clk_i,
  input  logic                          load_i,
  input  logic [oesc_pkg::WIDTH_W-1:0]  width_i,
  input  logic [oesc_pkg::TPU_W-1:0]    tpu_i,
  input  logic [oesc_pkg::TICK_W-1:0]   ticks_i,
  output logic                          fall_o
);

  logic [oesc_pkg::PROD_W-1:0] prod;
  logic [oesc_pkg::TICK_W-1:0] target_q;

  assign prod = oesc_pkg::PROD_W'(width_i) * oesc_pkg::PROD_W'(tpu_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      target_q <= prod[oesc_pkg::PROD_W-1:4];
    end
  end

  assign fall_o = (ticks_i >= target_q);

endmodule

[rtl/oesc_calib.sv]
// Calibration sequencer: microsecond prescaler, period and phase timers.
module oesc_calib (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          tick_i,
  input  logic [oesc_pkg::TPU_W-1:0]    tpu_i,
  output oesc_pkg::calib_status_t       status_o
);

  logic [oesc_pkg::TPU_W-1:0]    presc_q, presc_d;
  logic [oesc_pkg::PERIOD_W-1:0] period_q, period_d, period_inc;
  logic [oesc_pkg::ELAPSE_W-1:0] elapsed_q, elapsed_d, elapsed_inc;
  oesc_pkg::phase_e              phase_q, phase_d, phase_nxt;
  logic [oesc_pkg::TPU_W-1:0]    tpu_eff;
  logic [oesc_pkg::PERIOD_W-1:0] high_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      presc_q   <= '0;
      period_q  <= '0;
      elapsed_q <= '0;
      phase_q   <= oesc_pkg::PH_IDLE;
    end else begin
      presc_q   <= presc_d;
      period_q  <= period_d;
      elapsed_q <= elapsed_d;
      phase_q   <= phase_d;
    end
  end

  assign tpu_eff     = (tpu_i == '0) ? oesc_pkg::TPU_W'(1) : tpu_i;
  assign period_inc  = period_q + oesc_pkg::PERIOD_W'(1);
  assign elapsed_inc = elapsed_q + oesc_pkg::ELAPSE_W'(1);

  always_comb begin
    unique case (phase_q)
      oesc_pkg::PH_WAIT:  phase_nxt = oesc_pkg::PH_SHORT;
      oesc_pkg::PH_SHORT: phase_nxt = oesc_pkg::PH_HIGH;
      oesc_pkg::PH_HIGH:  phase_nxt = oesc_pkg::PH_LONG;
      default:            phase_nxt = oesc_pkg::PH_IDLE;
    endcase
  end

  always_comb begin
    presc_d   = presc_q;
    period_d  = period_q;
    elapsed_d = elapsed_q;
    phase_d   = phase_q;
    if (start_i) begin
      presc_d   = '0;
      period_d  = '0;
      elapsed_d = '0;
      phase_d   = oesc_pkg::PH_WAIT;
    end else if (tick_i && phase_q != oesc_pkg::PH_IDLE) begin
      if (({1'b0, presc_q} + 11'd1) >= {1'b0, tpu_eff}) begin
        presc_d   = '0;
        elapsed_d = elapsed_inc;
        period_d  = (period_inc >= oesc_pkg::PERIOD_US) ? '0 : period_inc;
        if (elapsed_inc >= oesc_pkg::phase_length(phase_q)) begin
          elapsed_d = '0;
          period_d  = '0;
          phase_d   = phase_nxt;
        end
      end else begin
        presc_d = presc_q + oesc_pkg::TPU_W'(1);
      end
    end
  end

  assign high_len = (phase_d == oesc_pkg::PH_HIGH) ? oesc_pkg::HIGH_US : oesc_pkg::LOW_US;

  assign status_o.phase_q    = phase_q;
  assign status_o.phase_d    = phase_d;
  assign status_o.pulse_high = (phase_d == oesc_pkg::PH_SHORT || phase_d == oesc_pkg::PH_HIGH ||
                                phase_d == oesc_pkg::PH_LONG) && (period_d < high_len);

endmodule

[rtl/oesc_checker.sv]
// Port-level checks of the pulse generator and their binding.
`include "oneshot_esc_pulse_generator_defines.svh"

module oesc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           req_valid_i,
  input logic                           req_ready_i,
  input logic                           res_valid_i,
  input logic                           res_ready_i,
  input logic [oesc_pkg::NUM_LANES-1:0] res_levels_i,
  input logic                           res_busy_i,
  input logic [2:0]                     res_phase_i
);

  `OESC_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i)
  `OESC_ASSERT_NEXT(a_req_gives_res, req_valid_i && req_ready_i, res_valid_i)
  `OESC_ASSERT(a_level_busy, !res_valid_i || res_levels_i == '0 || res_busy_i)
  `OESC_ASSERT(a_phase_busy, !res_valid_i || res_phase_i == oesc_pkg::PH_IDLE || res_busy_i)

endmodule

bind oneshot_esc_pulse_generator oesc_checker u_oesc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .res_levels_i (res_o.pin_levels),
  .res_busy_i   (res_o.busy_res),
  .res_phase_i  (res_o.calib_phase)
);

[tb/tb.sv]
// Self-checking testbench of the pulse generator: directed table, random frames, calibration.
module tb;

  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]                                           mode;
    logic [oesc_pkg::NUM_LANES-1:0][oesc_pkg::WIDTH_W-1:0] w;
  } esc_req_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    esc_req_t                        req;
    int                              reps;
    bit                              typed;
    oesc_pkg::result_t               want;
    logic [oesc_pkg::CFG_IDX_W-1:0]  idx;
    logic [oesc_pkg::CFG_DATA_W-1:0] data;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  oesc_req_if req_if();
  oesc_cfg_if cfg_if();
  oesc_res_if res_if();

  oneshot_esc_pulse_generator #(
    .MAX_CHANNELS(8)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  logic [oesc_pkg::TPU_W-1:0]     tpu_q;
  logic [oesc_pkg::ACT_W-1:0]     act_q;
  logic [oesc_pkg::TICK_W-1:0]    frame_cnt;
  logic [oesc_pkg::TICK_W-1:0]    tgt [oesc_pkg::NUM_LANES];
  logic [oesc_pkg::NUM_LANES-1:0] lvl;
  bit                             in_frame;
  logic [oesc_pkg::TPU_W-1:0]     us_div;
  logic [oesc_pkg::PERIOD_W-1:0]  per_us;
  logic [oesc_pkg::ELAPSE_W-1:0]  elapsed_us;
  oesc_pkg::phase_e               ph;

  oesc_pkg::result_t levels_due [$];

  int src_idle;
  int snk_idle;
  int errors;
  int n_req;
  int n_frames;
  int n_refused;
  int n_calib;
  int n_cfg;
  int n_checked;
  int hold_left;
  bit hold_req;
  bit hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $error("run did not finish in time, %0d results still outstanding", levels_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [oesc_pkg::NUM_LANES-1:0] chan_mask();
    int n;
    n = (act_q > oesc_pkg::NUM_LANES) ? oesc_pkg::NUM_LANES : int'(act_q);
    return oesc_pkg::NUM_LANES'((1 << n) - 1);
  endfunction

  function automatic void esc_tick();
    logic [oesc_pkg::ELAPSE_W-1:0] span;
    logic [oesc_pkg::PERIOD_W-1:0] hi;
    int                            tpu_eff;
    if (in_frame) begin
      if (frame_cnt < oesc_pkg::TICK_MAX) frame_cnt++;
      for (int i = 0; i < oesc_pkg::NUM_LANES; i++) begin
        if (lvl[i] && frame_cnt >= tgt[i]) lvl[i] = 1'b0;
      end
      if (lvl == '0) in_frame = 1'b0;
    end else if (ph != oesc_pkg::PH_IDLE) begin
      tpu_eff = (tpu_q == '0) ? 1 : int'(tpu_q);
      if (int'(us_div) + 1 >= tpu_eff) begin
        us_div = '0;
        elapsed_us++;
        per_us++;
        if (per_us >= oesc_pkg::PERIOD_US) per_us = '0;
        span = (ph == oesc_pkg::PH_WAIT)  ? oesc_pkg::WAIT_US :
               (ph == oesc_pkg::PH_SHORT) ? oesc_pkg::SHORT_PHASE_US :
                                            oesc_pkg::LONG_PHASE_US;
        if (elapsed_us >= span) begin
          elapsed_us = '0;
          per_us = '0;
          ph = (ph == oesc_pkg::PH_LONG) ? oesc_pkg::PH_IDLE : oesc_pkg::phase_e'(ph + 3'd1);
        end
      end else begin
        us_div++;
      end
      hi = (ph == oesc_pkg::PH_HIGH) ? oesc_pkg::HIGH_US : oesc_pkg::LOW_US;
      lvl = (ph >= oesc_pkg::PH_SHORT && ph <= oesc_pkg::PH_LONG && per_us < hi) ?
            chan_mask() : '0;
    end
  endfunction

  function automatic oesc_pkg::result_t esc_step(esc_req_t r);
    bit busy;
    bit rej;
    busy = in_frame || ph != oesc_pkg::PH_IDLE;
    rej = 1'b0;
    n_req++;
    if ((r.mode == oesc_pkg::MODE_FRAME || r.mode == oesc_pkg::MODE_CALIB) && busy) begin
      rej = 1'b1;
      n_refused++;
      esc_tick();
    end else if (r.mode == oesc_pkg::MODE_FRAME) begin
      for (int i = 0; i < oesc_pkg::NUM_LANES; i++) begin
        tgt[i] = oesc_pkg::TICK_W'((int'(r.w[i]) * int'(tpu_q)) >> 4);
      end
      frame_cnt = '0;
      lvl = chan_mask();
      in_frame = 1'b1;
      n_frames++;
    end else if (r.mode == oesc_pkg::MODE_CALIB) begin
      ph = oesc_pkg::PH_WAIT;
      us_div = '0;
      per_us = '0;
      elapsed_us = '0;
      lvl = '0;
      n_calib++;
    end else begin
      esc_tick();
    end
    return {lvl, (in_frame || ph != oesc_pkg::PH_IDLE), ph, rej};
  endfunction

  function automatic esc_req_t pick_request();
    esc_req_t r;
    int       roll;
    int       sel;
    r.w = {$urandom, $urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (!(in_frame || ph != oesc_pkg::PH_IDLE)) begin
      if (roll < 55) begin
        r.mode = oesc_pkg::MODE_FRAME;
        for (int i = 0; i < oesc_pkg::NUM_LANES; i++) begin
          sel = $urandom_range(0, 99);
          r.w[i] = (sel < 10) ? '0 :
                   (sel < 18) ? oesc_pkg::WIDTH_W'($urandom_range(0, 1023)) :
                                oesc_pkg::WIDTH_W'($urandom_range(1, 96));
        end
      end else begin
        r.mode = (roll < 85) ? oesc_pkg::MODE_TICK : MODE_SPARE;
      end
    end else begin
      r.mode = (roll < 70) ? oesc_pkg::MODE_TICK :
               (roll < 80) ? MODE_SPARE :
               (roll < 93) ? oesc_pkg::MODE_FRAME : oesc_pkg::MODE_CALIB;
    end
    return r;
  endfunction

  function automatic stim_row_t mk_req(logic [1:0] mode,
                                       logic [oesc_pkg::NUM_LANES*oesc_pkg::WIDTH_W-1:0] widths,
                                       int reps, bit typed, oesc_pkg::result_t want);
    stim_row_t row;
    row.kind = ROW_REQ;
    row.req = {mode, widths};
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    row.idx = '0;
    row.data = '0;
    return row;
  endfunction

  function automatic stim_row_t mk_cfg(logic [oesc_pkg::CFG_IDX_W-1:0] idx,
                                       logic [oesc_pkg::CFG_DATA_W-1:0] data);
    stim_row_t row;
    row.kind = ROW_CFG;
    row.req = '0;
    row.reps = 0;
    row.typed = 1'b0;
    row.want = '0;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic send_req(esc_req_t r, bit typed, oesc_pkg::result_t want);
    oesc_pkg::result_t got;
    while ($urandom_range(0, 99) < src_idle) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= r.mode;
    req_if.width_0 <= r.w[0];
    req_if.width_1 <= r.w[1];
    req_if.width_2 <= r.w[2];
    req_if.width_3 <= r.w[3];
    req_if.width_4 <= r.w[4];
    req_if.width_5 <= r.w[5];
    req_if.width_6 <= r.w[6];
    req_if.width_7 <= r.w[7];
    do @(posedge clk_i); while (!req_if.ready);
    got = esc_step(r);
    levels_due.push_back(typed ? want : got);
  endtask

  task automatic quiesce();
    req_if.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [oesc_pkg::CFG_IDX_W-1:0] idx,
                           logic [oesc_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == oesc_pkg::CFG_TICKS_PER_US) tpu_q = data[oesc_pkg::TPU_W-1:0];
    else if (idx == oesc_pkg::CFG_ACTIVE_CHANNELS) act_q = data[oesc_pkg::ACT_W-1:0];
    n_cfg++;
    @(posedge clk_i);
  endtask

  initial begin
    oesc_pkg::result_t due;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        n_checked++;
        if (levels_due.size() == 0) begin
          $error("result arrived with nothing outstanding");
          errors++;
        end else begin
          due = levels_due.pop_front();
          if (res_if.pin_levels !== due.pin_levels) begin
            $error("pin_levels: expected %02h, got %02h", due.pin_levels, res_if.pin_levels);
            errors++;
          end
          if (res_if.busy_res !== due.busy_res) begin
            $error("busy_res: expected %0d, got %0d", due.busy_res, res_if.busy_res);
            errors++;
          end
          if (res_if.calib_phase !== due.calib_phase) begin
            $error("calib_phase: expected %0d, got %0d", due.calib_phase, res_if.calib_phase);
            errors++;
          end
          if (res_if.rejected !== due.rejected) begin
            $error("rejected: expected %0d, got %0d", due.rejected, res_if.rejected);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        res_if.ready <= 1'b0;
        hold_left = 59;
        hold_done = 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(0, 99) >= snk_idle);
      end
    end
  end

  initial begin
    stim_row_t tbl [$];
    esc_req_t  r;
    int        sent;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = oesc_pkg::MODE_TICK;
    req_if.width_0 = '0;
    req_if.width_1 = '0;
    req_if.width_2 = '0;
    req_if.width_3 = '0;
    req_if.width_4 = '0;
    req_if.width_5 = '0;
    req_if.width_6 = '0;
    req_if.width_7 = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.idx     = oesc_pkg::CFG_TICKS_PER_US;
    cfg_if.data    = '0;
    src_idle = 32;
    snk_idle = 83;

    tpu_q = oesc_pkg::TPU_RESET;
    act_q = oesc_pkg::ACT_RESET;
    frame_cnt = '0;
    foreach (tgt[i]) tgt[i] = '0;
    lvl = '0;
    in_frame = 1'b0;
    us_div = '0;
    per_us = '0;
    elapsed_us = '0;
    ph = oesc_pkg::PH_IDLE;

    tbl.push_back(mk_req(oesc_pkg::MODE_TICK, '0, 1, 1'b1,
                         {8'h00, 1'b0, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(MODE_SPARE, '1, 1, 1'b1, {8'h00, 1'b0, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, '0, 1, 1'b1,
                         {8'h0F, 1'b1, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(oesc_pkg::MODE_TICK, '1, 1, 1'b1,
                         {8'h00, 1'b0, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_TICKS_PER_US, 10'd1023));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_ACTIVE_CHANNELS, 10'd15));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, '0, 1, 1'b1,
                         {8'hFF, 1'b1, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, '1, 1, 1'b1,
                         {8'h00, 1'b0, oesc_pkg::PH_IDLE, 1'b1}));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_TICKS_PER_US, 10'd1));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_ACTIVE_CHANNELS, 10'd0));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, '1, 1, 1'b1,
                         {8'h00, 1'b1, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(oesc_pkg::MODE_CALIB, '1, 1, 1'b1,
                         {8'h00, 1'b0, oesc_pkg::PH_IDLE, 1'b1}));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_TICKS_PER_US, 10'd0));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_ACTIVE_CHANNELS, 10'd8));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, '1, 1, 1'b1,
                         {8'hFF, 1'b1, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(MODE_SPARE, '0, 1, 1'b1, {8'h00, 1'b0, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_TICKS_PER_US, 10'd16));
    tbl.push_back(mk_cfg(oesc_pkg::CFG_ACTIVE_CHANNELS, 10'd3));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, {{5{12'hFFF}}, 12'd3, 12'd0, 12'd1}, 1, 1'b1,
                         {8'h07, 1'b1, oesc_pkg::PH_IDLE, 1'b0}));
    tbl.push_back(mk_req(oesc_pkg::MODE_FRAME, '0, 1, 1'b1,
                         {8'h04, 1'b1, oesc_pkg::PH_IDLE, 1'b1}));
    tbl.push_back(mk_req(oesc_pkg::MODE_TICK, '0, 2, 1'b0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tbl[k]) begin
      if (tbl[k].kind == ROW_CFG) begin
        quiesce();
        cfg_write(tbl[k].idx, tbl[k].data);
      end else begin
        repeat (tbl[k].reps) send_req(tbl[k].req, tbl[k].typed, tbl[k].want);
      end
    end

    for (int p = 0; p < 3; p++) begin
      quiesce();
      case (p)
        0: begin
          src_idle = 32;
          snk_idle = 83;
          cfg_write(oesc_pkg::CFG_TICKS_PER_US, 10'd1);
          cfg_write(oesc_pkg::CFG_ACTIVE_CHANNELS, 10'd8);
        end
        1: begin
          src_idle = 83;
          snk_idle = 32;
          cfg_write(oesc_pkg::CFG_TICKS_PER_US, 10'd4);
          cfg_write(oesc_pkg::CFG_ACTIVE_CHANNELS, 10'd15);
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
          cfg_write(oesc_pkg::CFG_TICKS_PER_US,
                    oesc_pkg::CFG_DATA_W'($urandom_range(1, 3)));
          cfg_write(oesc_pkg::CFG_ACTIVE_CHANNELS,
                    oesc_pkg::CFG_DATA_W'($urandom_range(0, 15)));
          hold_req = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < 165 || in_frame) begin
        send_req(pick_request(), 1'b0, '0);
        sent++;
      end
    end

    // calibration never ends within the run, so start it last
    r = pick_request();
    r.mode = oesc_pkg::MODE_CALIB;
    send_req(r, 1'b0, '0);
    repeat (40) send_req(pick_request(), 1'b0, '0);
    req_if.valid <= 1'b0;

    while (levels_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d requests: %0d frames started, %0d starts refused, %0d calibration",
             n_req, n_frames, n_refused, n_calib);
    $display("%0d register writes, %0d results compared, %0d mismatches",
             n_cfg, n_checked, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/oesc_pkg.sv
rtl/oesc_if.sv
rtl/oesc_lane.sv
rtl/oesc_calib.sv
rtl/oneshot_esc_pulse_generator.sv
rtl/oesc_checker.sv
tb/tb.sv
